FILE: src/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg
// shared types and constants for the riff audio chunk locator
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam logic [31:0] RIFF_ID  = 32'h4646_4952;
  localparam logic [31:0] WAVE_ID  = 32'h4556_4157;
  localparam logic [31:0] FMT_ID   = 32'h2074_6D66;
  localparam logic [31:0] DATA_ID  = 32'h6174_6164;
  localparam logic [15:0] COMP_MP3 = 16'h0055;
  localparam logic [31:0] RIFF_HDR = 32'd8;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MP3  = 3'd1;
  localparam logic [2:0] KIND_WAV  = 3'd2;
  localparam logic [2:0] KIND_RIFF = 3'd3;
  localparam logic [2:0] KIND_BAD  = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [30:0] asset_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  payload_kind;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } res_item_t;

  // handshake between the byte stage and the parser
  typedef struct packed {
    logic consume;
  } stage_ctl_t;

endpackage

FILE: src/rac_in_reg.sv
// ----------------------------------------------------------------------------
// rac_in_reg
// input register stage holding one byte transaction for the parser
// ----------------------------------------------------------------------------
module rac_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  rac_pkg::in_item_t item,
  output rac_pkg::in_item_t stage_item,
  input  logic              consume,
  output logic              stage_valid
);
  import rac_pkg::*;

  logic held;
  logic held_next;
  in_item_t buf_item;

  assign ready       = !held || consume;
  assign held_next   = (valid && ready) || (held && !consume);
  assign stage_valid = held;
  assign stage_item  = buf_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      buf_item <= item;
    end
  end

endmodule

FILE: src/rac_parser.sv
// ----------------------------------------------------------------------------
// rac_parser
// header walk state and one-byte next-state logic with result decision
// ----------------------------------------------------------------------------
module rac_parser (
  input  logic               clk,
  input  logic               rst,
  input  rac_pkg::in_item_t  item,
  input  logic               item_valid,
  input  logic               out_free,
  output rac_pkg::stage_ctl_t ctl,
  output logic               res_load,
  output rac_pkg::res_item_t res
);
  import rac_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_TAG       = 4'd1;
  localparam logic [3:0] PH_RIFFLEN   = 4'd2;
  localparam logic [3:0] PH_FORM      = 4'd3;
  localparam logic [3:0] PH_FMT_TAG   = 4'd4;
  localparam logic [3:0] PH_FMT_LEN   = 4'd5;
  localparam logic [3:0] PH_FMT_SKIP  = 4'd6;
  localparam logic [3:0] PH_COMP      = 4'd7;
  localparam logic [3:0] PH_DATA_TAG  = 4'd8;
  localparam logic [3:0] PH_DATA_LEN  = 4'd9;
  localparam logic [3:0] PH_DATA_SKIP = 4'd10;
  localparam logic [3:0] PH_DONE      = 4'd11;

  logic [3:0]  phase, phase_next;
  logic [1:0]  fcnt, fcnt_next;
  logic [31:0] pos, pos_next;
  logic [31:0] riff_end, riff_end_next;
  logic [31:0] shift, shift_next;
  logic [31:0] tag, tag_next;
  logic [31:0] skip, skip_next;
  logic [30:0] size, size_next;
  logic        decided, decided_next;

  logic        emit;
  logic        done;
  logic [31:0] word;
  logic [31:0] target;
  logic [31:0] rest;
  res_item_t   res_next;
  logic        go;

  always_comb begin
    phase_next    = phase;
    fcnt_next     = fcnt;
    pos_next      = pos;
    riff_end_next = riff_end;
    shift_next    = shift;
    tag_next      = tag;
    skip_next     = skip;
    size_next     = size;
    decided_next  = decided;
    emit          = 1'b0;
    done          = 1'b0;
    word          = '0;
    target        = '0;
    rest          = '0;
    res_next      = '{payload_kind: KIND_NONE, payload_offset: '0, payload_length: '0};

    if (item.first_byte) begin
      phase_next    = PH_TAG;
      fcnt_next     = '0;
      pos_next      = '0;
      riff_end_next = '0;
      shift_next    = '0;
      tag_next      = '0;
      skip_next     = '0;
      size_next     = item.asset_size;
      decided_next  = 1'b0;
    end

    if (!decided_next) begin
      // skip phases just count down; other phases shift in a byte
      if (phase_next == PH_FMT_SKIP || phase_next == PH_DATA_SKIP) begin
        if (skip_next <= 32'd1) begin
          skip_next  = '0;
          phase_next = (phase_next == PH_FMT_SKIP) ? PH_FMT_TAG : PH_DATA_TAG;
        end else begin
          skip_next = skip_next - 32'd1;
        end
      end else begin
        shift_next = {item.data_byte, shift_next[31:8]};
        if ((phase_next == PH_COMP) ? (fcnt_next >= 2'd1) : (fcnt_next == 2'd3)) begin
          fcnt_next = '0;
          word      = shift_next;
          done      = 1'b1;
        end else begin
          fcnt_next = fcnt_next + 2'd1;
        end
      end

      pos_next = pos_next + 32'd1;

      if (done) begin
        unique case (phase_next)
          PH_TAG: begin
            if (word == RIFF_ID) begin
              phase_next = PH_RIFFLEN;
            end else begin
              emit     = 1'b1;
              res_next = '{KIND_MP3, 32'd0, {1'b0, size_next}};
            end
          end
          PH_RIFFLEN: begin
            riff_end_next = word + RIFF_HDR;
            phase_next    = PH_FORM;
          end
          PH_FORM: begin
            if (word != WAVE_ID) begin
              emit     = 1'b1;
              res_next = '{KIND_BAD, 32'd0, 32'd0};
            end else if (pos_next >= riff_end_next) begin
              emit     = 1'b1;
              res_next = '{KIND_WAV, 32'd0, {1'b0, size_next}};
            end else begin
              phase_next = PH_FMT_TAG;
            end
          end
          PH_FMT_TAG, PH_DATA_TAG: begin
            tag_next   = word;
            phase_next = (phase_next == PH_FMT_TAG) ? PH_FMT_LEN : PH_DATA_LEN;
          end
          PH_FMT_LEN: begin
            if (tag_next == FMT_ID) begin
              skip_next  = word;
              phase_next = PH_COMP;
            end else begin
              target = pos_next + word;
              if (target >= riff_end_next) begin
                emit     = 1'b1;
                res_next = '{KIND_WAV, 32'd0, {1'b0, size_next}};
              end else begin
                skip_next  = word;
                phase_next = (word == 32'd0) ? PH_FMT_TAG : PH_FMT_SKIP;
              end
            end
          end
          PH_COMP: begin
            if (word[31:16] != COMP_MP3) begin
              emit     = 1'b1;
              res_next = '{KIND_WAV, 32'd0, {1'b0, size_next}};
            end else begin
              // rest of the fmt body after the compression word
              rest   = (skip_next >= 32'd2) ? (skip_next - 32'd2) : 32'd0;
              target = pos_next + rest;
              if (target >= riff_end_next) begin
                emit     = 1'b1;
                res_next = '{KIND_NONE, 32'd0, 32'd0};
              end else begin
                skip_next  = rest;
                phase_next = (rest == 32'd0) ? PH_DATA_TAG : PH_DATA_SKIP;
              end
            end
          end
          PH_DATA_LEN: begin
            if (tag_next == DATA_ID) begin
              emit     = 1'b1;
              res_next = '{KIND_RIFF, pos_next, word};
            end else begin
              target = pos_next + word;
              if (target >= riff_end_next) begin
                emit     = 1'b1;
                res_next = '{KIND_NONE, 32'd0, 32'd0};
              end else begin
                skip_next  = word;
                phase_next = (word == 32'd0) ? PH_DATA_TAG : PH_DATA_SKIP;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // asset ends before a decision
      if (!emit && item.last_byte) begin
        emit = 1'b1;
        unique case (phase_next)
          PH_TAG:                    res_next = '{KIND_MP3, 32'd0, {1'b0, size_next}};
          PH_RIFFLEN, PH_FORM:       res_next = '{KIND_BAD, 32'd0, 32'd0};
          PH_FMT_TAG, PH_FMT_LEN,
          PH_FMT_SKIP, PH_COMP:      res_next = '{KIND_WAV, 32'd0, {1'b0, size_next}};
          default:                   res_next = '{KIND_NONE, 32'd0, 32'd0};
        endcase
      end

      if (emit) begin
        decided_next = 1'b1;
        phase_next   = PH_DONE;
      end
    end
  end

  assign go          = item_valid && (!emit || out_free);
  assign ctl.consume = go;
  assign res_load    = go && emit;
  assign res         = res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      fcnt     <= '0;
      pos      <= '0;
      riff_end <= '0;
      shift    <= '0;
      tag      <= '0;
      skip     <= '0;
      size     <= '0;
      decided  <= 1'b1;
    end else if (go) begin
      phase    <= phase_next;
      fcnt     <= fcnt_next;
      pos      <= pos_next;
      riff_end <= riff_end_next;
      shift    <= shift_next;
      tag      <= tag_next;
      skip     <= skip_next;
      size     <= size_next;
      decided  <= decided_next;
    end
  end

endmodule

FILE: src/rac_out_reg.sv
// ----------------------------------------------------------------------------
// rac_out_reg
// result register holding one result transaction for the consumer
// ----------------------------------------------------------------------------
module rac_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rac_pkg::res_item_t load_item,
  output logic               free,
  output logic               valid,
  input  logic               ready,
  output rac_pkg::res_item_t item
);
  import rac_pkg::*;

  logic      full;
  logic      full_next;
  res_item_t buf_item;

  assign free      = !full || ready;
  assign full_next = load || (full && !ready);
  assign valid     = full;
  assign item      = buf_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_item <= load_item;
    end
  end

endmodule

FILE: src/riff_audio_chunk_locator.sv
// a result is loaded into the output register as the parser consumes the byte that decides it
// one byte per cycle, save for the stall below; the header walk update is combinational
// a pending result stalls only bytes that would make another result
// reset: synchronous rst clears both stage valids and returns the parser to idle
// ----------------------------------------------------------------------------
// riff_audio_chunk_locator
// locates the audio payload of a riff/wave or raw mp3 asset from its byte stream
// ----------------------------------------------------------------------------
module riff_audio_chunk_locator (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  rac_pkg::in_item_t  src_item,
  output logic               res_valid,
  input  logic               res_ready,
  output rac_pkg::res_item_t res_item
);
  import rac_pkg::*;

  in_item_t   stage_item;
  logic       stage_valid;
  stage_ctl_t ctl;
  logic       out_free;
  logic       res_load;
  res_item_t  res_next;

  rac_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .valid       (src_valid),
    .ready       (src_ready),
    .item        (src_item),
    .stage_item  (stage_item),
    .consume     (ctl.consume),
    .stage_valid (stage_valid)
  );

  rac_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item       (stage_item),
    .item_valid (stage_valid),
    .out_free   (out_free),
    .ctl        (ctl),
    .res_load   (res_load),
    .res        (res_next)
  );

  rac_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_item (res_next),
    .free      (out_free),
    .valid     (res_valid),
    .ready     (res_ready),
    .item      (res_item)
  );

endmodule
